@@ rtl/core/lsvd_pkg.sv @@
// Shared types and constants for the LIFO stack with delete-by-value.
package lsvd_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 7;

    // Read value returned by a pop or peek on an empty stack.
    localparam logic signed [DATA_W-1:0] EMPTY_READ = -32'sd1;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    // Request payload.
    typedef struct packed {
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] operand_value;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
    } rsp_t;

    // Memory access issued by the controller in one cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

@@ rtl/core/lsvd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module lsvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/lsvd_ctrl.sv @@
// Command sequencer: keeps the count, drives the entry memory and builds responses.
module lsvd_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  lsvd_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output lsvd_pkg::rsp_t                    rsp,
    output lsvd_pkg::ram_req_t                ram_req,
    input  logic [lsvd_pkg::DATA_W-1:0]       rdata,
    output logic [lsvd_pkg::CNT_W-1:0]        count
);

    localparam int AW = lsvd_pkg::ADDR_W;
    localparam int CW = lsvd_pkg::CNT_W;
    localparam int DW = lsvd_pkg::DATA_W;

    lsvd_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    lsvd_pkg::cmd_t    op_reg, op_next;
    logic [DW-1:0]     val_reg, val_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DW-1:0]     res_read_reg, res_read_next;
    lsvd_pkg::status_t res_stat_reg, res_stat_next;
    logic              rsp_valid_reg, rsp_valid_next;
    lsvd_pkg::rsp_t    rsp_reg, rsp_next;

    logic          accept;
    logic          is_full;
    logic          is_zero;
    logic [AW-1:0] top_addr;
    logic [CW-1:0] idx_ext;
    logic          match;
    logic          scan_last;
    logic          at_top;
    logic          shift_last;
    logic          rsp_free;

    // Shared decode.
    assign accept     = req_valid && (state_reg == lsvd_pkg::S_IDLE);
    assign is_full    = count_reg == CW'(lsvd_pkg::STACK_DEPTH);
    assign is_zero    = count_reg == '0;
    assign top_addr   = AW'(count_reg - CW'(1));
    assign idx_ext    = CW'(idx_reg);
    assign match      = rdata == val_reg;
    assign scan_last  = idx_reg == '0;
    assign at_top     = (idx_ext + CW'(1)) == count_reg;
    assign shift_last = (idx_ext + CW'(2)) == count_reg;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsvd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == lsvd_pkg::CMD_PUSH || is_zero)
                    begin
                        state_next = lsvd_pkg::S_RESP;
                    end
                    else if (req.cmd == lsvd_pkg::CMD_DELETE)
                    begin
                        state_next = lsvd_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = lsvd_pkg::S_READ;
                    end
                end
            end
            lsvd_pkg::S_READ:
            begin
                state_next = lsvd_pkg::S_RESP;
            end
            lsvd_pkg::S_SCAN:
            begin
                if (match)
                begin
                    state_next = at_top ? lsvd_pkg::S_RESP : lsvd_pkg::S_SHIFT;
                end
                else if (scan_last)
                begin
                    state_next = lsvd_pkg::S_RESP;
                end
            end
            lsvd_pkg::S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = lsvd_pkg::S_RESP;
                end
            end
            lsvd_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = lsvd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lsvd_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory access and response.
    always_comb
    begin
        count_next     = count_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        res_read_next  = res_read_reg;
        res_stat_next  = res_stat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_req        = '0;

        // The held response leaves when the consumer takes it.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            lsvd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req.cmd;
                    val_next      = req.operand_value;
                    res_read_next = '0;
                    res_stat_next = lsvd_pkg::STAT_OK;
                    case (req.cmd)
                        lsvd_pkg::CMD_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_stat_next = lsvd_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = AW'(count_reg);
                                ram_req.wdata = req.operand_value;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        lsvd_pkg::CMD_POP, lsvd_pkg::CMD_PEEK:
                        begin
                            if (is_zero)
                            begin
                                res_read_next = lsvd_pkg::EMPTY_READ;
                                res_stat_next = lsvd_pkg::STAT_EMPTY;
                            end
                            ram_req.raddr = top_addr;
                        end
                        lsvd_pkg::CMD_DELETE:
                        begin
                            if (is_zero)
                            begin
                                res_stat_next = lsvd_pkg::STAT_EMPTY;
                            end
                            ram_req.raddr = top_addr;
                            idx_next      = top_addr;
                        end
                        default:
                        begin
                            res_stat_next = lsvd_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            lsvd_pkg::S_READ:
            begin
                // Top entry arrives from the memory.
                res_read_next = rdata;
                if (op_reg == lsvd_pkg::CMD_POP)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            lsvd_pkg::S_SCAN:
            begin
                // Compare the entry read last cycle, walking down from the top.
                if (match)
                begin
                    if (at_top)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        ram_req.raddr = idx_reg + AW'(1);
                    end
                end
                else if (scan_last)
                begin
                    res_stat_next = lsvd_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    ram_req.raddr = idx_reg - AW'(1);
                    idx_next      = idx_reg - AW'(1);
                end
            end
            lsvd_pkg::S_SHIFT:
            begin
                // Move the entry above down by one place, reading one ahead.
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = rdata;
                if (shift_last)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    ram_req.raddr = idx_reg + AW'(2);
                    idx_next      = idx_reg + AW'(1);
                end
            end
            lsvd_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.read_value  = res_read_reg;
                    rsp_next.status      = res_stat_reg;
                    rsp_next.entry_count = count_reg;
                    rsp_next.is_empty    = is_zero;
                end
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsvd_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        res_read_reg <= res_read_next;
        res_stat_reg <= res_stat_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = state_reg != lsvd_pkg::S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign count     = count_reg;

endmodule

@@ rtl/core/lifo_stack_with_value_delete_unit.sv @@
// LIFO stack with delete-by-value: top level joining the sequencer and the entry memory.
// Push goes straight to the response; pop and peek read the top entry first unless the
// stack is empty; delete scans down from the top entry, then shifts the entries above a
// match down. A request is taken only when idle; one is taken while a response waits.
// Delete time is set by the single read port of the entry memory, one access per cycle.
// Reset clears the count and the handshake; the entry memory is not cleared.
module lifo_stack_with_value_delete_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lsvd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lsvd_pkg::rsp_t rsp
);

    lsvd_pkg::ram_req_t                ram_req;
    logic [lsvd_pkg::DATA_W-1:0]       rdata;
    logic [lsvd_pkg::CNT_W-1:0]        count;

    // Command sequencer.
    lsvd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .rdata     (rdata),
        .count     (count)
    );

    // Entry memory.
    lsvd_ram #(
        .WIDTH (lsvd_pkg::DATA_W),
        .DEPTH (lsvd_pkg::STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    // The count never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count <= lsvd_pkg::CNT_W'(lsvd_pkg::STACK_DEPTH))
    else $error("stack count above depth");

    // Memory writes stay within the held entries plus the push slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (lsvd_pkg::CNT_W'(ram_req.waddr) <= count))
    else $error("memory write beyond top of stack");

    // An accepted request stalls the request side in the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous one still in work");

    // A refused push reports a full stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == lsvd_pkg::STAT_FULL)
            |-> (rsp.entry_count == lsvd_pkg::CNT_W'(lsvd_pkg::STACK_DEPTH)))
    else $error("full status with stack not full");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the LIFO stack with delete-by-value.
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * lsvd_pkg::STACK_DEPTH + 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 135;
    localparam int PRINT_CAP      = 100;
    localparam int PLAN_ROWS      = 25;
    localparam lsvd_pkg::rsp_t NO_TYPED = '0;

    // One row of the directed plan; reps repeats the command with the value stepping by one.
    typedef struct {
        lsvd_pkg::cmd_t                     cmd;
        logic signed [lsvd_pkg::DATA_W-1:0] value;
        int                                 reps;
        bit                                 typed;
        lsvd_pkg::rsp_t                     want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    lsvd_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    lsvd_pkg::rsp_t rsp;

    // Typed expectation that travels alongside the request being offered.
    logic drive_typed = 1'b0;
    lsvd_pkg::rsp_t drive_typed_rsp = '0;

    // Shadow copy of the stack.
    logic signed [lsvd_pkg::DATA_W-1:0] shadow_words [lsvd_pkg::STACK_DEPTH];
    int shadow_count = 0;

    lsvd_pkg::rsp_t pending_rsp [$];
    plan_row_t plan [PLAN_ROWS];
    logic signed [lsvd_pkg::DATA_W-1:0] value_pool [8];

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_armed = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int offered = 0;
    int cmd_seen [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};
    int peak_depth = 0;
    int responses = 0;

    lifo_stack_with_value_delete_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one command to the shadow stack and return the response it should produce.
    function automatic lsvd_pkg::rsp_t stack_apply(lsvd_pkg::req_t r);
        lsvd_pkg::rsp_t o;
        int             hit;
        o.read_value = '0;
        o.status     = lsvd_pkg::STAT_OK;
        case (r.cmd)
            lsvd_pkg::CMD_PUSH:
            begin
                if (shadow_count >= lsvd_pkg::STACK_DEPTH)
                    o.status = lsvd_pkg::STAT_FULL;
                else
                begin
                    shadow_words[shadow_count] = r.operand_value;
                    shadow_count++;
                end
            end
            lsvd_pkg::CMD_POP, lsvd_pkg::CMD_PEEK:
            begin
                if (shadow_count == 0)
                begin
                    o.read_value = lsvd_pkg::EMPTY_READ;
                    o.status     = lsvd_pkg::STAT_EMPTY;
                end
                else
                begin
                    o.read_value = shadow_words[shadow_count - 1];
                    if (r.cmd == lsvd_pkg::CMD_POP)
                        shadow_count--;
                end
            end
            default:
            begin
                if (shadow_count == 0)
                    o.status = lsvd_pkg::STAT_EMPTY;
                else
                begin
                    // Search from the top down; the nearest match wins.
                    hit = -1;
                    for (int i = shadow_count - 1; i >= 0 && hit < 0; i--)
                        if (shadow_words[i] == r.operand_value)
                            hit = i;
                    if (hit < 0)
                        o.status = lsvd_pkg::STAT_NOT_FOUND;
                    else
                    begin
                        for (int k = hit; k + 1 < shadow_count; k++)
                            shadow_words[k] = shadow_words[k + 1];
                        shadow_count--;
                    end
                end
            end
        endcase
        o.entry_count = lsvd_pkg::CNT_W'(shadow_count);
        o.is_empty    = (shadow_count == 0);
        return o;
    endfunction

    // Print one mismatch line (up to a cap) and count it.
    task automatic flag_mismatch(string what);
        if (error_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Record accepted requests and check accepted responses against the oldest expectation.
    always @(posedge clk)
    begin : handshake_monitor
        lsvd_pkg::rsp_t want;
        if (rst_n && req_valid && !req_stall)
        begin
            want = stack_apply(req);
            if (drive_typed)
                want = drive_typed_rsp;
            pending_rsp.push_back(want);
            cmd_seen[req.cmd]++;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            responses++;
            if (pending_rsp.size() == 0)
                flag_mismatch("response with no request outstanding");
            else
            begin
                want = pending_rsp.pop_front();
                status_seen[want.status]++;
                if (int'(want.entry_count) > peak_depth)
                    peak_depth = int'(want.entry_count);
                if (rsp.read_value !== want.read_value)
                    flag_mismatch($sformatf("read_value got %0d want %0d",
                                            rsp.read_value, want.read_value));
                if (rsp.status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            rsp.status, want.status));
                if (rsp.entry_count !== want.entry_count)
                    flag_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp.entry_count, want.entry_count));
                if (rsp.is_empty !== want.is_empty)
                    flag_mismatch($sformatf("is_empty got %0b want %0b",
                                            rsp.is_empty, want.is_empty));
            end
        end
    end

    // Response side: one long hold-off when armed, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_armed && hold_cnt < HOLD_CYCLES)
        begin
            rsp_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end
        else
            rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, pending_rsp.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request, with optional idle cycles first, and wait until it is taken.
    task automatic offer(lsvd_pkg::cmd_t c, logic signed [lsvd_pkg::DATA_W-1:0] v,
                         bit typed, lsvd_pkg::rsp_t want);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        req             <= '{cmd: c, operand_value: v};
        drive_typed     <= typed;
        drive_typed_rsp <= want;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        offered++;
    endtask

    // Values from a small pool at the given percentage, so pushes collide and deletes find matches.
    function automatic logic signed [lsvd_pkg::DATA_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // One burst of random requests, of a single flavor or a random mix.
    task automatic random_burst();
        int kind;
        int len;
        kind = $urandom_range(99);
        if ($urandom_range(9) == 0)
            value_pool[$urandom_range(7)] = $urandom;
        if (kind < 30)
        begin
            len = $urandom_range(8, 1);
            repeat (len) offer(lsvd_pkg::CMD_PUSH, pick_value(70), 1'b0, NO_TYPED);
        end
        else if (kind < 50)
        begin
            len = $urandom_range(6, 1);
            repeat (len)
                offer($urandom_range(1) ? lsvd_pkg::CMD_POP : lsvd_pkg::CMD_PEEK,
                      $urandom, 1'b0, NO_TYPED);
        end
        else if (kind < 75)
        begin
            len = $urandom_range(4, 1);
            repeat (len) offer(lsvd_pkg::CMD_DELETE, pick_value(85), 1'b0, NO_TYPED);
        end
        else if (kind < 90)
        begin
            len = $urandom_range(6, 1);
            repeat (len)
                offer(lsvd_pkg::cmd_t'($urandom_range(3)), pick_value(50), 1'b0, NO_TYPED);
        end
        else if (kind < 95)
            repeat (lsvd_pkg::STACK_DEPTH + 2)
                offer(lsvd_pkg::CMD_PUSH, pick_value(60), 1'b0, NO_TYPED);
        else
            repeat (lsvd_pkg::STACK_DEPTH + 2)
                offer(lsvd_pkg::CMD_POP, $urandom, 1'b0, NO_TYPED);
    endtask

    // Run random bursts until a phase's share of requests has gone in.
    task automatic random_phase(int idle, int stall);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = offered + PHASE_ITEMS;
        while (offered < target)
            random_burst();
    endtask

    initial
    begin
        // Directed plan: empty cases, extremes, duplicates, deep shifts and a full stack.
        plan = '{
            '{lsvd_pkg::CMD_POP,    32'sd0,         1,  1'b1,
              '{lsvd_pkg::EMPTY_READ, lsvd_pkg::STAT_EMPTY, 7'd0, 1'b1}},
            '{lsvd_pkg::CMD_PEEK,   32'sd0,         1,  1'b1,
              '{lsvd_pkg::EMPTY_READ, lsvd_pkg::STAT_EMPTY, 7'd0, 1'b1}},
            '{lsvd_pkg::CMD_DELETE, 32'sd5,         1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_EMPTY, 7'd0, 1'b1}},
            '{lsvd_pkg::CMD_PUSH,   32'sh7FFF_FFFF, 1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_OK, 7'd1, 1'b0}},
            '{lsvd_pkg::CMD_PUSH,   32'sh8000_0000, 1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_OK, 7'd2, 1'b0}},
            '{lsvd_pkg::CMD_PUSH,   32'sd0,         1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_OK, 7'd3, 1'b0}},
            '{lsvd_pkg::CMD_PUSH,   -32'sd1,        1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_OK, 7'd4, 1'b0}},
            '{lsvd_pkg::CMD_PEEK,   32'sd0,         1,  1'b1,
              '{-32'sd1, lsvd_pkg::STAT_OK, 7'd4, 1'b0}},
            '{lsvd_pkg::CMD_DELETE, 32'sd12345,     1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_NOT_FOUND, 7'd4, 1'b0}},
            '{lsvd_pkg::CMD_PUSH,   32'sh8000_0000, 1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_OK, 7'd5, 1'b0}},
            '{lsvd_pkg::CMD_DELETE, 32'sh8000_0000, 1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_OK, 7'd4, 1'b0}},
            '{lsvd_pkg::CMD_PEEK,   32'sd0,         1,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_DELETE, 32'sh7FFF_FFFF, 1,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_POP,    32'sd0,         3,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_POP,    32'sd0,         1,  1'b1,
              '{lsvd_pkg::EMPTY_READ, lsvd_pkg::STAT_EMPTY, 7'd0, 1'b1}},
            '{lsvd_pkg::CMD_PUSH,   32'sd1000,      64, 1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_PUSH,   32'sd0,         1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_FULL, 7'd64, 1'b0}},
            '{lsvd_pkg::CMD_DELETE, 32'sd1000,      1,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_DELETE, 32'sd1063,      1,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_DELETE, 32'sd999,       1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_NOT_FOUND, 7'd62, 1'b0}},
            '{lsvd_pkg::CMD_PUSH,   32'sh8000_0000, 1,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_PEEK,   32'sd0,         1,  1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_POP,    32'sd0,         63, 1'b0, NO_TYPED},
            '{lsvd_pkg::CMD_POP,    32'sd0,         1,  1'b1,
              '{lsvd_pkg::EMPTY_READ, lsvd_pkg::STAT_EMPTY, 7'd0, 1'b1}},
            '{lsvd_pkg::CMD_DELETE, 32'sd0,         1,  1'b1,
              '{32'sd0, lsvd_pkg::STAT_EMPTY, 7'd0, 1'b1}}
        };
        value_pool = '{32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       $urandom, $urandom, $urandom, $urandom};

        // Hold reset low, then release it.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with both sides running freely.
        foreach (plan[i])
            for (int k = 0; k < plan[i].reps; k++)
                offer(plan[i].cmd, plan[i].value + k, plan[i].typed, plan[i].want);

        // Random part over phases of request idling and response stalling.
        random_phase(0, 0);
        random_phase(67, 0);
        random_phase(0, 67);
        random_phase(29, 29);

        // Long receiver hold-off while requests keep coming, so the input backs up.
        hold_armed = 1'b1;
        random_phase(0, 0);

        // Let every outstanding response come back, then watch for strays.
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: push %0d, pop %0d, peek %0d, delete %0d.",
                 offered, cmd_seen[lsvd_pkg::CMD_PUSH], cmd_seen[lsvd_pkg::CMD_POP],
                 cmd_seen[lsvd_pkg::CMD_PEEK], cmd_seen[lsvd_pkg::CMD_DELETE]);
        $display("Responses %0d: ok %0d, empty %0d, full %0d, not found %0d; peak depth %0d.",
                 responses, status_seen[lsvd_pkg::STAT_OK],
                 status_seen[lsvd_pkg::STAT_EMPTY], status_seen[lsvd_pkg::STAT_FULL],
                 status_seen[lsvd_pkg::STAT_NOT_FOUND], peak_depth);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lsvd_pkg.sv
rtl/core/lsvd_ram.sv
rtl/core/lsvd_ctrl.sv
rtl/core/lifo_stack_with_value_delete_unit.sv
verif/testbench.sv
